/* rtl/id3p_pkg.sv */
// Shared types and constants of the ID3v2 text frame parser.
package id3p_pkg;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND   = 2'd1;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;
   localparam logic [2:0] NO_FIELD           = 3'd7;
   localparam logic [6:0] SYNCSAFE_MASK      = 7'h7F;

   typedef struct packed {
      logic       result_kind;
      logic [2:0] field_code;
      logic [7:0] text_byte;
      logic       byte_valid;
      logic       field_start;
      logic       field_end;
      logic [1:0] tag_status;
      logic [7:0] major_version;
      logic [7:0] minor_version;
   } result_type;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_FHDR   = 4'b0010,
      PH_DATA   = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   function automatic logic [2:0] match_field(input logic [31:0] ident);
      logic [31:0] s;
      logic [2:0]  f;
      s = ident;
      if (ident[31:24] == 8'd0) begin
         s = 32'd0;
      end else if (ident[23:16] == 8'd0) begin
         s = {ident[31:24], 24'd0};
      end else if (ident[15:8] == 8'd0) begin
         s = {ident[31:16], 16'd0};
      end
      f = NO_FIELD;
      unique case (s)
         32'h54495432, 32'h54543200: f = 3'd0;
         32'h54504531, 32'h54503100: f = 3'd1;
         32'h54414C42, 32'h54414C00: f = 3'd2;
         32'h54594552, 32'h54594500: f = 3'd3;
         32'h54434F4E, 32'h54434F00: f = 3'd4;
         32'h5452434B, 32'h54524B00: f = 3'd5;
         32'h434F4D4D, 32'h434F4D00: f = 3'd6;
         default: f = NO_FIELD;
      endcase
      return f;
   endfunction

endpackage

/* rtl/id3p_front.sv */
// Front part: walks the tag header and frame headers and classifies each byte.
module id3p_front
   import id3p_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       max_text_chars,
   input  logic             in_valid,
   output logic             in_stall,
   input  logic [7:0]       data_byte,
   input  logic             end_of_stream,
   output logic             q_valid,
   input  logic             q_full,
   output result_type       q_data
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in;
   logic        sig_ff, sig_in;
   logic [7:0]  major_ff, major_in, minor_ff, minor_in;
   logic [27:0] tlen_ff, tlen_in;
   logic [28:0] tpos_ff, tpos_in;
   logic [31:0] ident_ff, ident_in, flen_ff, flen_in, rem_ff, rem_in;
   logic [2:0]  field_ff, field_in;
   logic        stop_ff, stop_in;
   logic [7:0]  kept_ff, kept_in;

   logic        fire, v22, first, last, keep;
   logic [3:0]  hsize;
   logic [31:0] ident_next, flen_next;
   logic [29:0] tpos_hdr;
   logic [32:0] tpos_end;
   logic [1:0]  st;

   assign in_stall = q_full;
   assign fire = in_valid && !q_full;
   assign v22 = (major_ff == 8'd2);
   assign hsize = v22 ? 4'd6 : 4'd10;

   always_comb begin
      phase_in = phase_ff; idx_in = idx_ff; sig_in = sig_ff;
      major_in = major_ff; minor_in = minor_ff; tlen_in = tlen_ff;
      tpos_in = tpos_ff; ident_in = ident_ff; flen_in = flen_ff;
      rem_in = rem_ff; field_in = field_ff; stop_in = stop_ff; kept_in = kept_ff;
      q_valid = 1'b0; q_data = '0; keep = 1'b0; st = STATUS_NOT_FOUND;
      ident_next = ident_ff; flen_next = flen_ff;
      tpos_hdr = {1'b0, tpos_ff} + {26'd0, hsize};
      tpos_end = {4'd0, tpos_hdr[28:0]} + {1'b0, flen_ff};
      first = (rem_ff == flen_ff);
      last = (rem_ff <= 32'd1);
      unique case (phase_ff)
         PH_HEADER: begin
            if ((idx_ff == 4'd0 && data_byte != 8'h49) ||
                (idx_ff == 4'd1 && data_byte != 8'h44) ||
                (idx_ff == 4'd2 && data_byte != 8'h33)) sig_in = 1'b0;
            if (idx_ff == 4'd3) major_in = data_byte;
            if (idx_ff == 4'd4) minor_in = data_byte;
            if (idx_ff >= 4'd6)
               tlen_in = {tlen_ff[20:0], data_byte[6:0] & SYNCSAFE_MASK};
            if (idx_ff >= 4'd9 || end_of_stream) begin
               if (idx_ff >= 4'd9 && sig_ff) begin
                  if (major_ff == 8'd4) st = STATUS_UNSUPPORTED;
                  else if (major_ff == 8'd2 || major_ff == 8'd3) st = STATUS_OK;
               end
               q_valid = 1'b1;
               q_data.result_kind = 1'b1;
               q_data.tag_status = st;
               q_data.major_version = major_in;
               q_data.minor_version = minor_in;
               if (st == STATUS_OK) begin
                  tpos_in = '0;
                  if ({26'd0, hsize} > {2'd0, tlen_in}) phase_in = PH_DONE;
                  else begin
                     phase_in = PH_FHDR; idx_in = '0; ident_in = '0; flen_in = '0;
                  end
               end else phase_in = PH_DONE;
            end else idx_in = idx_ff + 4'd1;
         end
         PH_FHDR: begin
            if (idx_ff < (v22 ? 4'd3 : 4'd4)) begin
               ident_next = ident_ff | ({24'd0, data_byte} << (5'd24 - {idx_ff[1:0], 3'd0}));
            end else if (idx_ff < (v22 ? 4'd6 : 4'd8)) begin
               flen_next = {flen_ff[23:0], data_byte};
            end
            ident_in = ident_next; flen_in = flen_next;
            tpos_end = {4'd0, tpos_hdr[28:0]} + {1'b0, flen_next};
            if (idx_ff + 4'd1 >= hsize) begin
               if (ident_next == 32'd0) phase_in = PH_DONE;
               else begin
                  tpos_in = tpos_hdr[28:0];
                  if (flen_next == 32'd0 || tpos_end > {5'd0, tlen_ff})
                     phase_in = PH_DONE;
                  else begin
                     tpos_in = tpos_end[28:0];
                     rem_in = flen_next;
                     field_in = match_field(ident_next);
                     stop_in = 1'b0; kept_in = '0; phase_in = PH_DATA;
                  end
               end
            end else idx_in = idx_ff + 4'd1;
         end
         PH_DATA: begin
            if (field_ff != NO_FIELD) begin
               if (!(first && data_byte <= 8'd1) && !stop_ff) begin
                  if (kept_ff >= max_text_chars || data_byte == 8'd0) stop_in = 1'b1;
                  else if (data_byte >= 8'd32 || data_byte == 8'd9) begin
                     keep = 1'b1; kept_in = kept_ff + 8'd1;
                  end
               end
               q_valid = 1'b1;
               q_data.field_code = field_ff;
               q_data.text_byte = keep ? data_byte : 8'd0;
               q_data.byte_valid = keep;
               q_data.field_start = first;
               q_data.field_end = last;
            end
            if (last) begin
               rem_in = '0; field_in = NO_FIELD;
               if ({1'b0, tpos_hdr} > {3'd0, tlen_ff}) phase_in = PH_DONE;
               else begin
                  phase_in = PH_FHDR; idx_in = '0; ident_in = '0; flen_in = '0;
               end
            end else rem_in = rem_ff - 32'd1;
         end
         PH_DONE: begin
         end
         default: phase_in = PH_DONE;
      endcase
      q_valid = q_valid && fire;
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && end_of_stream)) begin
         phase_ff <= PH_HEADER; idx_ff <= '0; sig_ff <= 1'b1;
         major_ff <= '0; minor_ff <= '0; tlen_ff <= '0; tpos_ff <= '0;
         ident_ff <= '0; flen_ff <= '0; rem_ff <= '0; field_ff <= NO_FIELD;
         stop_ff <= 1'b0; kept_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in; idx_ff <= idx_in; sig_ff <= sig_in;
         major_ff <= major_in; minor_ff <= minor_in; tlen_ff <= tlen_in;
         tpos_ff <= tpos_in; ident_ff <= ident_in; flen_ff <= flen_in;
         rem_ff <= rem_in; field_ff <= field_in; stop_ff <= stop_in;
         kept_ff <= kept_in;
      end
   end

endmodule

/* rtl/id3p_queue.sv */
// Two-entry result queue between the front and the output channel.
module id3p_queue
   import id3p_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_valid,
   input  result_type wr_data,
   output logic       full,
   output logic       rd_valid,
   input  logic       rd_stall,
   output result_type rd_data
);

   result_type mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign full = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data = mem_ff[rptr_ff];
   assign pop = rd_valid && !rd_stall;

   always_ff @(posedge clock) begin
      if (wr_valid) mem_ff[wptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0; rptr_ff <= 1'b0; count_ff <= '0;
      end else begin
         if (wr_valid) wptr_ff <= !wptr_ff;
         if (pop) rptr_ff <= !rptr_ff;
         count_ff <= count_ff + {1'b0, wr_valid} - {1'b0, pop};
      end
   end

endmodule

/* rtl/id3v2_text_frame_parser_unit.sv */
// Top level of the ID3v2 text frame parser.
// Each byte is handled on acceptance; one byte per cycle while req_stall is low.
// A result enters the queue and reaches the rsp_ channel after older results.
// A two-entry queue decouples the front from the output; req_stall rises only
// when full. A synchronous reset clears all but queue data; max_text_chars gets 63.
module id3v2_text_frame_parser_unit
   import id3p_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_result_kind,
   output logic [2:0] rsp_field_code,
   output logic [7:0] rsp_text_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_field_start,
   output logic       rsp_field_end,
   output logic [1:0] rsp_tag_status,
   output logic [7:0] rsp_major_version,
   output logic [7:0] rsp_minor_version
);

   logic [7:0] max_chars_ff;
   logic       q_valid, q_full;
   result_type q_data, r;

   always_ff @(posedge clock) begin
      if (reset) max_chars_ff <= 8'd63;
      else if (csr_write_enable) max_chars_ff <= csr_write_data;
   end

   id3p_front u_front (
      .clock, .reset, .max_text_chars(max_chars_ff),
      .in_valid(req_valid), .in_stall(req_stall),
      .data_byte(req_data_byte), .end_of_stream(req_end_of_stream),
      .q_valid, .q_full, .q_data
   );

   id3p_queue u_queue (
      .clock, .reset, .wr_valid(q_valid), .wr_data(q_data), .full(q_full),
      .rd_valid(rsp_valid), .rd_stall(rsp_stall), .rd_data(r)
   );

   assign rsp_result_kind   = r.result_kind;
   assign rsp_field_code    = r.field_code;
   assign rsp_text_byte     = r.text_byte;
   assign rsp_byte_valid    = r.byte_valid;
   assign rsp_field_start   = r.field_start;
   assign rsp_field_end     = r.field_end;
   assign rsp_tag_status    = r.tag_status;
   assign rsp_major_version = r.major_version;
   assign rsp_minor_version = r.minor_version;

endmodule
